FILE: sv/fhss_pkg.sv
// ---------------------------------------------------------------------------
// fhss_pkg
// Types and codes shared by the feeder homing and step sequencer.
// ---------------------------------------------------------------------------
package fhss_pkg;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_DISPENSE = 2'd1;
  localparam logic [1:0] OP_STOP     = 2'd2;
  localparam logic [1:0] OP_RAMP     = 2'd3;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_HOMING     = 3'd1;
  localparam logic [2:0] PH_DISPENSING = 3'd2;
  localparam logic [2:0] PH_RAMPING    = 3'd3;
  localparam logic [2:0] PH_COMPLETE   = 3'd4;

  localparam logic [1:0] DRV_STOP = 2'd0;
  localparam logic [1:0] DRV_FWD  = 2'd1;
  localparam logic [1:0] DRV_REV  = 2'd2;

  localparam logic [1:0] SUB_NONE = 2'd0;
  localparam logic [1:0] SUB_HIGH = 2'd1;
  localparam logic [1:0] SUB_LOW  = 2'd2;
  localparam logic [1:0] SUB_GAP  = 2'd3;

  localparam logic [2:0] REG_STEPS_PER_ITEM   = 3'd0;
  localparam logic [2:0] REG_PULSE_HALF       = 3'd1;
  localparam logic [2:0] REG_STEP_GAP         = 3'd2;
  localparam logic [2:0] REG_ITEM_GAP         = 3'd3;
  localparam logic [2:0] REG_RAMP_DOWN        = 3'd4;
  localparam logic [2:0] REG_STATUS_INTERVAL  = 3'd5;

  localparam int unsigned ADDR_W = 5;

  localparam logic [15:0] RST_STEPS_PER_ITEM  = 16'd200;
  localparam logic [15:0] RST_PULSE_HALF      = 16'd1000;
  localparam logic [15:0] RST_STEP_GAP        = 16'd1000;
  localparam logic [23:0] RST_ITEM_GAP        = 24'd100000;
  localparam logic [23:0] RST_RAMP_DOWN       = 24'd500000;
  localparam logic [23:0] RST_STATUS_INTERVAL = 24'd1000000;

  localparam logic [23:0] TMR_MAX = 24'hFF_FFFF;

  typedef struct packed {
    logic [15:0] steps_per_item;
    logic [15:0] pulse_half_ticks;
    logic [15:0] step_gap_ticks;
    logic [23:0] item_gap_ticks;
    logic [23:0] ramp_down_ticks;
    logic [23:0] status_interval_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] item_count;
    logic        limit_closed;
  } cmd_t;

  typedef struct packed {
    logic        step_pulse;
    logic        step_dir;
    logic [1:0]  feed_drive;
    logic [2:0]  phase;
    logic [15:0] items_done;
    logic [15:0] items_total;
    logic        status_pulse;
    logic        complete_pulse;
    logic        error_code;
  } result_t;

endpackage

FILE: sv/fhss_ifs.sv
// ---------------------------------------------------------------------------
// fhss channel interfaces
// Valid/ready channels for commands in and results out.
// ---------------------------------------------------------------------------
interface fhss_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] item_count;
  logic        limit_closed;

  modport source (output valid, opcode, item_count, limit_closed, input ready);
  modport sink   (input valid, opcode, item_count, limit_closed, output ready);
endinterface

interface fhss_res_if;
  logic        valid;
  logic        ready;
  logic        step_pulse;
  logic        step_dir;
  logic [1:0]  feed_drive;
  logic [2:0]  phase;
  logic [15:0] items_done;
  logic [15:0] items_total;
  logic        status_pulse;
  logic        complete_pulse;
  logic        error_code;

  modport source (output valid, step_pulse, step_dir, feed_drive, phase, items_done,
                  items_total, status_pulse, complete_pulse, error_code, input ready);
  modport sink   (input valid, step_pulse, step_dir, feed_drive, phase, items_done,
                  items_total, status_pulse, complete_pulse, error_code, output ready);
endinterface

FILE: sv/fhss_core.sv
// ---------------------------------------------------------------------------
// fhss_core
// Sequencer state and the single-pass update for one command or tick.
// ---------------------------------------------------------------------------
module fhss_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  fhss_pkg::cmd_t    cmd,
  input  fhss_pkg::cfg_t    cfg,
  output fhss_pkg::result_t result
);
  import fhss_pkg::*;

  logic [2:0]  phase, phase_next;
  logic [1:0]  drive, drive_next;
  logic [1:0]  sub, sub_next;
  logic        disp_flag, disp_flag_next;
  logic        stop_req, stop_req_next;
  logic        ramp_flag, ramp_flag_next;
  logic        dir, dir_next;
  logic [15:0] done_cnt, done_cnt_next;
  logic [15:0] total_cnt, total_cnt_next;
  logic [15:0] pulses_left, pulses_left_next;
  logic [23:0] itmr, itmr_next;
  logic [23:0] stmr, stmr_next;

  logic        status, complete, err;
  logic [15:0] half_eff;
  logic [23:0] sub_dur;
  logic [23:0] itmr_inc;
  logic [23:0] stmr_inc;
  logic        gap_zero;
  logic [15:0] gx_dec;
  logic [15:0] gx_pl;
  logic [1:0]  gx_sub;
  logic [15:0] done_inc;

  assign half_eff = (cfg.pulse_half_ticks == 16'd0) ? 16'd1 : cfg.pulse_half_ticks;
  assign gap_zero = (pulses_left != 16'd0) ? (cfg.step_gap_ticks == 16'd0)
                                           : (cfg.item_gap_ticks == 24'd0);
  assign itmr_inc = (itmr == TMR_MAX) ? itmr : itmr + 24'd1;
  assign stmr_inc = (stmr == TMR_MAX) ? stmr : stmr + 24'd1;
  assign done_inc = done_cnt + 16'd1;
  assign gx_dec   = pulses_left - 16'd1;

  always_comb begin
    unique case (sub)
      SUB_HIGH, SUB_LOW: sub_dur = {8'd0, half_eff};
      SUB_GAP:           sub_dur = (pulses_left != 16'd0) ? {8'd0, cfg.step_gap_ticks}
                                                          : cfg.item_gap_ticks;
      default:           sub_dur = 24'd1;
    endcase
  end

  // leave a gap subphase, going on through an item gap that takes no tick
  always_comb begin
    if (pulses_left != 16'd0) begin
      gx_pl = gx_dec;
      if (gx_dec != 16'd0) begin
        gx_sub = SUB_HIGH;
      end else if (cfg.item_gap_ticks != 24'd0) begin
        gx_sub = SUB_GAP;
      end else begin
        gx_sub = SUB_NONE;
      end
    end else begin
      gx_pl  = pulses_left;
      gx_sub = SUB_NONE;
    end
  end

  always_comb begin
    phase_next       = phase;
    drive_next       = drive;
    sub_next         = sub;
    disp_flag_next   = disp_flag;
    stop_req_next    = stop_req;
    ramp_flag_next   = ramp_flag;
    dir_next         = dir;
    done_cnt_next    = done_cnt;
    total_cnt_next   = total_cnt;
    pulses_left_next = pulses_left;
    itmr_next        = itmr;
    stmr_next        = stmr;
    status           = 1'b0;
    complete         = 1'b0;
    err              = 1'b0;

    unique case (cmd.opcode)
      OP_TICK: begin
        unique case (phase)
          PH_HOMING: begin
            if (cmd.limit_closed) begin
              drive_next = DRV_STOP;
              phase_next = disp_flag ? PH_DISPENSING : PH_IDLE;
            end
          end
          PH_DISPENSING: begin
            if (sub != SUB_NONE) begin
              itmr_next = itmr_inc;
              if (itmr_inc >= sub_dur) begin
                itmr_next = 24'd0;
                unique case (sub)
                  SUB_HIGH: sub_next = SUB_LOW;
                  SUB_LOW: begin
                    sub_next = SUB_GAP;
                    if (gap_zero) begin
                      sub_next         = gx_sub;
                      pulses_left_next = gx_pl;
                    end
                  end
                  default: begin
                    sub_next         = gx_sub;
                    pulses_left_next = gx_pl;
                  end
                endcase
                if (sub != SUB_HIGH && sub_next == SUB_NONE) begin
                  done_cnt_next = done_inc;
                  status        = 1'b1;
                end
              end
            end else if (done_cnt >= total_cnt || stop_req) begin
              phase_next     = PH_RAMPING;
              ramp_flag_next = 1'b1;
              itmr_next      = 24'd0;
              drive_next     = DRV_REV;
            end else if (!cmd.limit_closed) begin
              phase_next = PH_HOMING;
              drive_next = DRV_FWD;
            end else begin
              dir_next         = 1'b1;
              pulses_left_next = cfg.steps_per_item;
              itmr_next        = 24'd0;
              if (cfg.steps_per_item != 16'd0) begin
                sub_next = SUB_HIGH;
              end else if (cfg.item_gap_ticks != 24'd0) begin
                sub_next = SUB_GAP;
              end else begin
                sub_next      = SUB_NONE;
                done_cnt_next = done_inc;
                status        = 1'b1;
              end
            end
          end
          PH_RAMPING: begin
            itmr_next = itmr_inc;
            if (itmr_inc >= cfg.ramp_down_ticks) begin
              drive_next     = DRV_STOP;
              ramp_flag_next = 1'b0;
              phase_next     = PH_COMPLETE;
              complete       = 1'b1;
              status         = 1'b1;
            end
          end
          PH_COMPLETE: begin
            disp_flag_next = 1'b0;
            done_cnt_next  = 16'd0;
            total_cnt_next = 16'd0;
            phase_next     = PH_IDLE;
          end
          default: begin
          end
        endcase
        if (phase_next != PH_IDLE && phase_next != PH_COMPLETE) begin
          stmr_next = stmr_inc;
          if (stmr_inc >= cfg.status_interval_ticks) begin
            status    = 1'b1;
            stmr_next = 24'd0;
          end
        end
      end
      OP_DISPENSE: begin
        if (cmd.item_count == 16'd0) begin
          err = 1'b1;
        end else begin
          done_cnt_next    = 16'd0;
          total_cnt_next   = cmd.item_count;
          disp_flag_next   = 1'b1;
          ramp_flag_next   = 1'b0;
          stop_req_next    = 1'b0;
          sub_next         = SUB_NONE;
          pulses_left_next = 16'd0;
          itmr_next        = 24'd0;
          phase_next       = PH_HOMING;
          drive_next       = DRV_FWD;
          stmr_next        = 24'd0;
          status           = 1'b1;
        end
      end
      OP_STOP: begin
        if (disp_flag) begin
          stop_req_next = 1'b1;
        end
      end
      default: begin
        if (!ramp_flag) begin
          sub_next         = SUB_NONE;
          pulses_left_next = 16'd0;
          phase_next       = PH_RAMPING;
          ramp_flag_next   = 1'b1;
          itmr_next        = 24'd0;
          drive_next       = DRV_REV;
        end
      end
    endcase
  end

  always_comb begin
    result.step_pulse     = (sub_next == SUB_HIGH);
    result.step_dir       = dir_next;
    result.feed_drive     = drive_next;
    result.phase          = phase_next;
    result.items_done     = done_cnt_next;
    result.items_total    = total_cnt_next;
    result.status_pulse   = status;
    result.complete_pulse = complete;
    result.error_code     = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      drive       <= DRV_STOP;
      sub         <= SUB_NONE;
      disp_flag   <= 1'b0;
      stop_req    <= 1'b0;
      ramp_flag   <= 1'b0;
      dir         <= 1'b0;
      done_cnt    <= 16'd0;
      total_cnt   <= 16'd0;
      pulses_left <= 16'd0;
      itmr        <= 24'd0;
      stmr        <= 24'd0;
    end else if (accept) begin
      phase       <= phase_next;
      drive       <= drive_next;
      sub         <= sub_next;
      disp_flag   <= disp_flag_next;
      stop_req    <= stop_req_next;
      ramp_flag   <= ramp_flag_next;
      dir         <= dir_next;
      done_cnt    <= done_cnt_next;
      total_cnt   <= total_cnt_next;
      pulses_left <= pulses_left_next;
      itmr        <= itmr_next;
      stmr        <= stmr_next;
    end
  end

  a_idle_stopped: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> drive == DRV_STOP)
    else $error("feed motor driven while idle");

  a_burst_in_dispense: assert property (@(posedge clk) disable iff (rst)
    sub != SUB_NONE |-> phase == PH_DISPENSING)
    else $error("step burst outside dispensing");

  a_ramp_flag: assert property (@(posedge clk) disable iff (rst)
    ramp_flag == (phase == PH_RAMPING))
    else $error("ramp flag out of step with phase");

endmodule

FILE: sv/feeder_homing_step_sequencer.sv
// ---------------------------------------------------------------------------
// feeder_homing_step_sequencer
// Homing, stepper burst and ramp-down sequencer for a feed mechanism.
//
//   channel  dir  handshake              payload
//   cmd      in   valid/ready            opcode, item_count, limit_closed
//   res      out  valid/ready            step/feed levels, phase, counts, flags
//   apb      in   psel/penable/pwrite    6 registers at 4*i, write and read
//
// One command or tick per clock while cmd is ready; results are registered.
// A two-entry output stage (result register plus skid) keeps cmd ready while
// a result waits; cmd stalls only when both entries are full.
// rst clears the sequencer state and loads register defaults.
// ---------------------------------------------------------------------------
module feeder_homing_step_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  fhss_cmd_if.sink                      cmd,
  fhss_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fhss_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import fhss_pkg::*;

  cfg_t        cfg;
  cmd_t        cmd_in;
  result_t     result;
  result_t     head;
  result_t     skid;
  logic        head_valid;
  logic        skid_valid;
  logic        accept;
  logic        pop;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steps_per_item        <= RST_STEPS_PER_ITEM;
      cfg.pulse_half_ticks      <= RST_PULSE_HALF;
      cfg.step_gap_ticks        <= RST_STEP_GAP;
      cfg.item_gap_ticks        <= RST_ITEM_GAP;
      cfg.ramp_down_ticks       <= RST_RAMP_DOWN;
      cfg.status_interval_ticks <= RST_STATUS_INTERVAL;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_STEPS_PER_ITEM:  cfg.steps_per_item        <= pwdata[15:0];
        REG_PULSE_HALF:      cfg.pulse_half_ticks      <= pwdata[15:0];
        REG_STEP_GAP:        cfg.step_gap_ticks        <= pwdata[15:0];
        REG_ITEM_GAP:        cfg.item_gap_ticks        <= pwdata[23:0];
        REG_RAMP_DOWN:       cfg.ramp_down_ticks       <= pwdata[23:0];
        REG_STATUS_INTERVAL: cfg.status_interval_ticks <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STEPS_PER_ITEM:  prdata = {16'd0, cfg.steps_per_item};
      REG_PULSE_HALF:      prdata = {16'd0, cfg.pulse_half_ticks};
      REG_STEP_GAP:        prdata = {16'd0, cfg.step_gap_ticks};
      REG_ITEM_GAP:        prdata = {8'd0, cfg.item_gap_ticks};
      REG_RAMP_DOWN:       prdata = {8'd0, cfg.ramp_down_ticks};
      REG_STATUS_INTERVAL: prdata = {8'd0, cfg.status_interval_ticks};
      default:             prdata = 32'd0;
    endcase
  end

  assign cmd.ready           = !skid_valid;
  assign accept              = cmd.valid && cmd.ready;
  assign pop                 = head_valid && res.ready;
  assign cmd_in.opcode       = cmd.opcode;
  assign cmd_in.item_count   = cmd.item_count;
  assign cmd_in.limit_closed = cmd.limit_closed;

  fhss_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd_in),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!head_valid || pop) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        head_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!head_valid || pop) begin
      head <= skid_valid ? skid : result;
    end
    if (accept && head_valid && !pop) begin
      skid <= result;
    end
  end

  assign res.valid          = head_valid;
  assign res.step_pulse     = head.step_pulse;
  assign res.step_dir       = head.step_dir;
  assign res.feed_drive     = head.feed_drive;
  assign res.phase          = head.phase;
  assign res.items_done     = head.items_done;
  assign res.items_total    = head.items_total;
  assign res.status_pulse   = head.status_pulse;
  assign res.complete_pulse = head.complete_pulse;
  assign res.error_code     = head.error_code;

  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid entry held without a result in front");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    skid_valid && pop |=> head_valid && !skid_valid)
    else $error("skid entry lost on transfer");

  a_complete_reports: assert property (@(posedge clk) disable iff (rst)
    head_valid && head.complete_pulse |-> head.status_pulse)
    else $error("completion without status report");

endmodule
